/* rtl/tss_pkg.sv */
package tss_pkg;

  // Default size of the task table.
  localparam int MaxTasksDefault = 8;

  // Fixed field widths.
  localparam int FuncW   = 2;
  localparam int PeriodW = 16;
  localparam int TimeW   = 32;
  localparam int KindW   = 2;
  localparam int SlotW   = 3;
  localparam int CountW  = 16;
  localparam int DivCntW = 4;
  localparam int PcW     = 4;

  // Reset value of the loop period register.
  localparam logic [PeriodW-1:0] LoopPeriodReset = 16'd10;

  // Operation codes on the input side.
  localparam logic [FuncW-1:0] FuncRegister = 2'd0;
  localparam logic [FuncW-1:0] FuncStart    = 2'd1;
  localparam logic [FuncW-1:0] FuncLoop     = 2'd2;

  // Result kinds on the output side.
  localparam logic [KindW-1:0] KindRegStatus  = 2'd0;
  localparam logic [KindW-1:0] KindLoopStatus = 2'd1;
  localparam logic [KindW-1:0] KindTaskDue    = 2'd2;

  // Datapath actions, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_START,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_REG_DONE,
    OP_ELAPSED,
    OP_TIME,
    OP_READ,
    OP_CHECK,
    OP_LOOP_DONE
  } tss_op_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_F_REG,
    C_F_LOOP,
    C_F_START,
    C_DIV_BUSY,
    C_NO_TASKS,
    C_MORE_SLOTS
  } tss_cond_e;

  // One control word of the microprogram.
  typedef struct packed {
    tss_op_e        op;
    tss_cond_e      cond;
    logic [PcW-1:0] target;
    logic           accept;
  } tss_ctrl_t;

  // Flags handed from the datapath back to the sequencer.
  typedef struct packed {
    logic is_reg;
    logic is_loop;
    logic is_start;
    logic div_busy;
    logic no_tasks;
    logic more_slots;
    logic hold;
  } tss_stat_t;

  // Microprogram addresses.
  localparam logic [PcW-1:0] S_IDLE     = 4'd0;
  localparam logic [PcW-1:0] S_DISP0    = 4'd1;
  localparam logic [PcW-1:0] S_DISP1    = 4'd2;
  localparam logic [PcW-1:0] S_DISP2    = 4'd3;
  localparam logic [PcW-1:0] S_SKIP     = 4'd4;
  localparam logic [PcW-1:0] S_START    = 4'd5;
  localparam logic [PcW-1:0] S_REG      = 4'd6;
  localparam logic [PcW-1:0] S_DIV      = 4'd7;
  localparam logic [PcW-1:0] S_REG_END  = 4'd8;
  localparam logic [PcW-1:0] S_LOOP     = 4'd9;
  localparam logic [PcW-1:0] S_TIME     = 4'd10;
  localparam logic [PcW-1:0] S_READ     = 4'd11;
  localparam logic [PcW-1:0] S_CHECK    = 4'd12;
  localparam logic [PcW-1:0] S_LOOP_END = 4'd13;

  // Read-only microprogram store.
  function automatic tss_ctrl_t tss_rom(input logic [PcW-1:0] pc);
    tss_ctrl_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE, accept: 1'b0};
    case (pc)
      S_IDLE:     w = '{op: OP_LOAD,      cond: C_NO_IN,      target: S_IDLE,     accept: 1'b1};
      S_DISP0:    w = '{op: OP_NOP,       cond: C_F_REG,      target: S_REG,      accept: 1'b0};
      S_DISP1:    w = '{op: OP_NOP,       cond: C_F_LOOP,     target: S_LOOP,     accept: 1'b0};
      S_DISP2:    w = '{op: OP_NOP,       cond: C_F_START,    target: S_START,    accept: 1'b0};
      S_SKIP:     w = '{op: OP_NOP,       cond: C_ALWAYS,     target: S_IDLE,     accept: 1'b0};
      S_START:    w = '{op: OP_START,     cond: C_ALWAYS,     target: S_IDLE,     accept: 1'b0};
      S_REG:      w = '{op: OP_DIV_INIT,  cond: C_NEVER,      target: S_IDLE,     accept: 1'b0};
      S_DIV:      w = '{op: OP_DIV_STEP,  cond: C_DIV_BUSY,   target: S_DIV,      accept: 1'b0};
      S_REG_END:  w = '{op: OP_REG_DONE,  cond: C_ALWAYS,     target: S_IDLE,     accept: 1'b0};
      S_LOOP:     w = '{op: OP_ELAPSED,   cond: C_NEVER,      target: S_IDLE,     accept: 1'b0};
      S_TIME:     w = '{op: OP_TIME,      cond: C_NO_TASKS,   target: S_LOOP_END, accept: 1'b0};
      S_READ:     w = '{op: OP_READ,      cond: C_NEVER,      target: S_IDLE,     accept: 1'b0};
      S_CHECK:    w = '{op: OP_CHECK,     cond: C_MORE_SLOTS, target: S_READ,     accept: 1'b0};
      S_LOOP_END: w = '{op: OP_LOOP_DONE, cond: C_ALWAYS,     target: S_IDLE,     accept: 1'b0};
      default:    w = '{op: OP_NOP,       cond: C_ALWAYS,     target: S_IDLE,     accept: 1'b0};
    endcase
    return w;
  endfunction

endpackage

/* rtl/tss_ram.sv */
module tss_ram #(
  parameter int Width = 16,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tss_seq.sv */
module tss_seq
  import tss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  tss_stat_t stat_i,
  output tss_ctrl_t ctrl_o
);

  logic [PcW-1:0] pc_q, pc_d;
  tss_ctrl_t      ctrl;
  logic           jump;

  // Fetch the control word of the current step.
  assign ctrl   = tss_rom(pc_q);
  assign ctrl_o = ctrl;

  // Evaluate the jump condition of this step.
  always_comb begin
    case (ctrl.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_IN:      jump = !in_valid_i;
      C_F_REG:      jump = stat_i.is_reg;
      C_F_LOOP:     jump = stat_i.is_loop;
      C_F_START:    jump = stat_i.is_start;
      C_DIV_BUSY:   jump = stat_i.div_busy;
      C_NO_TASKS:   jump = stat_i.no_tasks;
      C_MORE_SLOTS: jump = stat_i.more_slots;
      default:      jump = 1'b0;
    endcase
  end

  // Next step: hold while the result register is full, else jump or advance.
  always_comb begin
    if (stat_i.hold) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* rtl/tss_datapath.sv */
module tss_datapath
  import tss_pkg::*;
#(
  parameter int MaxTasks = MaxTasksDefault,
  localparam int IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1,
  localparam int CntW = $clog2(MaxTasks + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tss_ctrl_t          ctrl_i,
  output tss_stat_t          stat_o,
  input  logic               in_valid_i,
  input  logic [FuncW-1:0]   func_i,
  input  logic [PeriodW-1:0] period_ms_i,
  input  logic               handler_present_i,
  input  logic [TimeW-1:0]   current_ms_i,
  input  logic               cfg_we_i,
  input  logic [PeriodW-1:0] cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [KindW-1:0]   kind_o,
  output logic               accepted_o,
  output logic [SlotW-1:0]   slot_index_o,
  output logic               overran_o,
  output logic [TimeW-1:0]   overrun_ms_o,
  output logic [TimeW-1:0]   release_ms_o,
  output logic               last_item_o
);

  // Latched input beat.
  logic [FuncW-1:0]   func_q;
  logic [PeriodW-1:0] period_q;
  logic               handler_q;
  logic [TimeW-1:0]   now_q;

  // Scheduler state.
  logic [PeriodW-1:0] lp_q;
  logic [TimeW-1:0]   prev_q;
  logic [CntW-1:0]    tc_q;
  logic [IdxW-1:0]    slot_q;
  logic [TimeW-1:0]   elapsed_q;
  logic               late_q;
  logic [TimeW-1:0]   ovrms_q;
  logic [TimeW-1:0]   rel_q;

  // Divider state.
  logic [PeriodW-1:0] rem_q;
  logic [PeriodW-1:0] quo_q;
  logic [DivCntW-1:0] div_cnt_q;

  // Result register.
  logic               out_valid_q;
  logic [KindW-1:0]   kind_q;
  logic               acc_q;
  logic [SlotW-1:0]   oslot_q;
  logic               ovr_q;
  logic [TimeW-1:0]   oovr_q;
  logic [TimeW-1:0]   orel_q;
  logic               last_q;

  // Table ports.
  logic               lpp_we, cnt_we, rd_en;
  logic [IdxW-1:0]    waddr;
  logic [CountW-1:0]  cnt_wdata, lpp_rd, cnt_rd;

  // Combinational helpers.
  logic [PeriodW:0]   r_sh;
  logic               r_ge;
  logic [PeriodW:0]   r_diff;
  logic               reg_ok;
  logic               due;
  logic               emit_req;
  logic               hold;
  logic               late;
  logic [TimeW-1:0]   rel;

  // Restoring divider, one quotient bit per step.
  assign r_sh   = {rem_q, quo_q[PeriodW-1]};
  assign r_ge   = r_sh >= {1'b0, lp_q};
  assign r_diff = r_sh - {1'b0, lp_q};

  // Registration is accepted only for an exact nonzero multiple, with a handler and room left.
  assign reg_ok = (tc_q < CntW'(MaxTasks)) && handler_q && (lp_q != '0)
                  && (rem_q == '0) && (quo_q != '0);

  // A task is due once its counter has reached its loops per period.
  assign due = cnt_rd >= lpp_rd;

  // Loop timing from the registered elapsed time.
  assign late = elapsed_q > TimeW'(lp_q);
  assign rel  = late ? now_q : prev_q + TimeW'(lp_q);

  // A result is produced only when the result register is free or being emptied.
  always_comb begin
    emit_req = (ctrl_i.op == OP_REG_DONE) || (ctrl_i.op == OP_LOOP_DONE)
               || ((ctrl_i.op == OP_CHECK) && due);
    hold     = emit_req && out_valid_q && out_stall_i;
  end

  // Flags for the sequencer.
  always_comb begin
    stat_o.is_reg     = func_q == FuncRegister;
    stat_o.is_loop    = func_q == FuncLoop;
    stat_o.is_start   = func_q == FuncStart;
    stat_o.div_busy   = div_cnt_q != '1;
    stat_o.no_tasks   = tc_q == '0;
    stat_o.more_slots = (CntW'(slot_q) + CntW'(1)) < tc_q;
    stat_o.hold       = hold;
  end

  // Table access: slot walk reads and updates, registration writes a new row.
  always_comb begin
    rd_en  = ctrl_i.op == OP_READ;
    lpp_we = (ctrl_i.op == OP_REG_DONE) && !hold && reg_ok;
    cnt_we = lpp_we || ((ctrl_i.op == OP_CHECK) && !hold);
    if (ctrl_i.op == OP_CHECK) begin
      waddr     = slot_q;
      cnt_wdata = due ? CountW'(1) : cnt_rd + CountW'(1);
    end else begin
      waddr     = tc_q[IdxW-1:0];
      cnt_wdata = '0;
    end
  end

  tss_ram #(
    .Width (CountW),
    .Depth (MaxTasks)
  ) u_lpp_ram (
    .clk_i   (clk_i),
    .we_i    (lpp_we),
    .waddr_i (waddr),
    .wdata_i (quo_q),
    .re_i    (rd_en),
    .raddr_i (slot_q),
    .rdata_o (lpp_rd)
  );

  tss_ram #(
    .Width (CountW),
    .Depth (MaxTasks)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (waddr),
    .wdata_i (cnt_wdata),
    .re_i    (rd_en),
    .raddr_i (slot_q),
    .rdata_o (cnt_rd)
  );

  // Control state: loop period, time base, task count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q        <= LoopPeriodReset;
      prev_q      <= '0;
      tc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lp_q <= cfg_data_i;
      end
      if (emit_req && !hold) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (ctrl_i.op)
        OP_START: prev_q <= now_q;
        OP_TIME:  prev_q <= rel;
        OP_REG_DONE: begin
          if (!hold && reg_ok) begin
            tc_q <= tc_q + CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        if (in_valid_i) begin
          func_q    <= func_i;
          period_q  <= period_ms_i;
          handler_q <= handler_present_i;
          now_q     <= current_ms_i;
        end
      end
      OP_DIV_INIT: begin
        rem_q     <= '0;
        quo_q     <= period_q;
        div_cnt_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q     <= r_ge ? r_diff[PeriodW-1:0] : r_sh[PeriodW-1:0];
        quo_q     <= {quo_q[PeriodW-2:0], r_ge};
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
      OP_ELAPSED: begin
        elapsed_q <= now_q - prev_q;
      end
      OP_TIME: begin
        late_q  <= late;
        ovrms_q <= late ? elapsed_q - TimeW'(lp_q) : '0;
        rel_q   <= rel;
        slot_q  <= '0;
      end
      OP_CHECK: begin
        if (!hold) begin
          slot_q <= slot_q + IdxW'(1);
        end
      end
      default: ;
    endcase
  end

  // Result payload, loaded together with the valid flag.
  always_ff @(posedge clk_i) begin
    if (emit_req && !hold) begin
      case (ctrl_i.op)
        OP_REG_DONE: begin
          kind_q  <= KindRegStatus;
          acc_q   <= reg_ok;
          oslot_q <= reg_ok ? SlotW'(tc_q) : '0;
          ovr_q   <= 1'b0;
          oovr_q  <= '0;
          orel_q  <= '0;
          last_q  <= 1'b1;
        end
        OP_CHECK: begin
          kind_q  <= KindTaskDue;
          acc_q   <= 1'b0;
          oslot_q <= SlotW'(slot_q);
          ovr_q   <= 1'b0;
          oovr_q  <= '0;
          orel_q  <= '0;
          last_q  <= 1'b0;
        end
        default: begin
          kind_q  <= KindLoopStatus;
          acc_q   <= 1'b0;
          oslot_q <= '0;
          ovr_q   <= late_q;
          oovr_q  <= ovrms_q;
          orel_q  <= rel_q;
          last_q  <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign accepted_o   = acc_q;
  assign slot_index_o = oslot_q;
  assign overran_o    = ovr_q;
  assign overrun_ms_o = oovr_q;
  assign release_ms_o = orel_q;
  assign last_item_o  = last_q;

endmodule

/* rtl/timeslice_task_scheduler_unit.sv */
// Channel   Direction  Handshake                   Beat carries
// in        input      in_valid_i / in_stall_o     func, period, handler flag, ms count
// out       output     out_valid_o / out_stall_i   one result (register, due or loop status)
// cfg       input      cfg_valid_i / cfg_ready_o   loop period in ms
//
// Steps: a register beat runs through the bit-serial divider before its status result;
// a loop pass times the loop, then reads and updates the table slot by slot;
// a start latches the time base. One beat is worked on at a time.
// Reset: the loop period returns to 10 ms, the time base and task count to zero.
// Stalls: a full result register holds the microprogram on its current step.
module timeslice_task_scheduler_unit
  import tss_pkg::*;
#(
  parameter int MaxTasks = MaxTasksDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FuncW-1:0]   func_i,
  input  logic [PeriodW-1:0] period_ms_i,
  input  logic               handler_present_i,
  input  logic [TimeW-1:0]   current_ms_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [PeriodW-1:0] cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [KindW-1:0]   kind_o,
  output logic               accepted_o,
  output logic [SlotW-1:0]   slot_index_o,
  output logic               overran_o,
  output logic [TimeW-1:0]   overrun_ms_o,
  output logic [TimeW-1:0]   release_ms_o,
  output logic               last_item_o
);

  tss_ctrl_t ctrl;
  tss_stat_t stat;

  // Input and configuration are taken only on the idle step.
  assign in_stall_o  = !ctrl.accept;
  assign cfg_ready_o = ctrl.accept;

  tss_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  tss_datapath #(
    .MaxTasks (MaxTasks)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .in_valid_i        (in_valid_i),
    .func_i            (func_i),
    .period_ms_i       (period_ms_i),
    .handler_present_i (handler_present_i),
    .current_ms_i      (current_ms_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .accepted_o        (accepted_o),
    .slot_index_o      (slot_index_o),
    .overran_o         (overran_o),
    .overrun_ms_o      (overrun_ms_o),
    .release_ms_o      (release_ms_o),
    .last_item_o       (last_item_o)
  );

`ifndef NO_ASSERTIONS
  // The sequencer only stalls on a step that produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.hold |-> (ctrl.op == OP_CHECK || ctrl.op == OP_REG_DONE ||
                   ctrl.op == OP_LOOP_DONE))
    else $error("sequencer held on a step without a result");

  // A new result only follows a result-producing step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctrl.op == OP_CHECK || ctrl.op == OP_REG_DONE ||
                                 ctrl.op == OP_LOOP_DONE))
    else $error("result appeared without a producing step");

  // The loop status closes its pass with the last marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_LOOP_DONE && !stat.hold) |=> (out_valid_o && last_item_o))
    else $error("loop status missing or not marked last");
`endif

endmodule

/* dv/tss_result_checker.sv */
`timescale 1ns / 100ps

module tss_result_checker
  import tss_pkg::*;
#(
  parameter int MaxTasks = MaxTasksDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [FuncW-1:0]   func_i,
  input  logic [PeriodW-1:0] period_ms_i,
  input  logic               handler_present_i,
  input  logic [TimeW-1:0]   current_ms_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [PeriodW-1:0] cfg_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [KindW-1:0]   kind_i,
  input  logic               accepted_i,
  input  logic [SlotW-1:0]   slot_index_i,
  input  logic               overran_i,
  input  logic [TimeW-1:0]   overrun_ms_i,
  input  logic [TimeW-1:0]   release_ms_i,
  input  logic               last_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int MaxReports = 10;

  // One result beat as it leaves the scheduler.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             accepted;
    logic [SlotW-1:0] slot;
    logic             overran;
    logic [TimeW-1:0] overrun_ms;
    logic [TimeW-1:0] release_ms;
    logic             last;
  } sched_result_t;

  // Our own copy of the scheduler state.
  logic [PeriodW-1:0] loop_period_q;
  logic [TimeW-1:0]   prev_ms_q;
  int unsigned        task_count_q;
  logic [CountW-1:0]  loops_per_period_q [MaxTasks];
  logic [CountW-1:0]  loop_count_q       [MaxTasks];

  // Results still owed by the scheduler, oldest first.
  sched_result_t owed_results [$];
  int            fails;
  int            pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic sched_result_t make_result(
    input logic [KindW-1:0] kind,
    input logic             accepted,
    input logic [SlotW-1:0] slot,
    input logic             overran,
    input logic [TimeW-1:0] overrun_ms,
    input logic [TimeW-1:0] release_ms,
    input logic             last
  );
    sched_result_t r;
    r.kind       = kind;
    r.accepted   = accepted;
    r.slot       = slot;
    r.overran    = overran;
    r.overrun_ms = overrun_ms;
    r.release_ms = release_ms;
    r.last       = last;
    return r;
  endfunction

  // Works out the results that one input beat causes and advances the state copy.
  task automatic schedule_beat(
    input logic [FuncW-1:0]   func,
    input logic [PeriodW-1:0] period,
    input logic               handler,
    input logic [TimeW-1:0]   now
  );
    logic             ok;
    int unsigned      quot;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] rel;
    logic [TimeW-1:0] ovr_ms;
    logic             ovr;
    case (func)
      FuncRegister: begin
        ok   = 1'b0;
        quot = 0;
        if (task_count_q < MaxTasks && handler && loop_period_q != '0) begin
          quot = period / loop_period_q;
          ok   = ((period % loop_period_q) == 0) && (quot != 0) && (quot <= 32'hFFFF);
        end
        if (ok) begin
          loops_per_period_q[task_count_q] = quot[CountW-1:0];
          loop_count_q[task_count_q]       = '0;
          owed_results.push_back(make_result(KindRegStatus, 1'b1,
                                             task_count_q[SlotW-1:0], 1'b0, '0, '0, 1'b1));
          task_count_q++;
        end else begin
          owed_results.push_back(make_result(KindRegStatus, 1'b0, '0, 1'b0, '0, '0, 1'b1));
        end
      end
      FuncStart: begin
        prev_ms_q = now;
      end
      FuncLoop: begin
        // Timing first: on time releases one loop period after the last release.
        elapsed = now - prev_ms_q;
        if (elapsed <= loop_period_q) begin
          ovr    = 1'b0;
          ovr_ms = '0;
          rel    = prev_ms_q + loop_period_q;
        end else begin
          ovr    = 1'b1;
          ovr_ms = elapsed - loop_period_q;
          rel    = now;
        end
        prev_ms_q = rel;
        // Then the task walk, slot by slot in order.
        for (int i = 0; i < MaxTasks; i++) begin
          if (i < task_count_q) begin
            if (loop_count_q[i] >= loops_per_period_q[i]) begin
              loop_count_q[i] = '0;
              owed_results.push_back(make_result(KindTaskDue, 1'b0, i[SlotW-1:0],
                                                 1'b0, '0, '0, 1'b0));
            end
            loop_count_q[i] = loop_count_q[i] + 1'b1;
          end
        end
        owed_results.push_back(make_result(KindLoopStatus, 1'b0, '0, ovr, ovr_ms, rel, 1'b1));
      end
      default: begin
        // The unused code is dropped without any effect.
      end
    endcase
  endtask

  // Compare each result beat with the oldest owed result, then predict new ones.
  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t seen;
    sched_result_t want;
    if (!rst_ni) begin
      loop_period_q = LoopPeriodReset;
      prev_ms_q     = '0;
      task_count_q  = 0;
      for (int i = 0; i < MaxTasks; i++) begin
        loops_per_period_q[i] = '0;
        loop_count_q[i]       = '0;
      end
      owed_results.delete();
      fails   = 0;
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = make_result(kind_i, accepted_i, slot_index_i, overran_i,
                           overrun_ms_i, release_ms_i, last_item_i);
        if (owed_results.size() == 0) begin
          fails++;
          if (fails <= MaxReports) begin
            $display("%0t: result beat with nothing owed: kind %0d acc %0d slot %0d",
                     $time, seen.kind, seen.accepted, seen.slot);
          end
        end else begin
          want = owed_results.pop_front();
          if (seen !== want) begin
            fails++;
            if (fails <= MaxReports) begin
              $display("%0t: result mismatch", $time);
              $display("  expected kind %0d acc %0d slot %0d ovr %0d ovr_ms %0d rel %0d last %0d",
                       want.kind, want.accepted, want.slot, want.overran,
                       want.overrun_ms, want.release_ms, want.last);
              $display("  actual   kind %0d acc %0d slot %0d ovr %0d ovr_ms %0d rel %0d last %0d",
                       seen.kind, seen.accepted, seen.slot, seen.overran,
                       seen.overrun_ms, seen.release_ms, seen.last);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        loop_period_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        schedule_beat(func_i, period_ms_i, handler_present_i, current_ms_i);
      end
      pending = owed_results.size();
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import tss_pkg::*;

  localparam logic [FuncW-1:0] FuncUnused = 2'd3;

  localparam int PhaseItems   = 88;
  localparam int SettleCycles = 30;
  localparam int LongHold     = 250;
  localparam int IdleLimit    = 4000;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [FuncW-1:0]   func_i;
  logic [PeriodW-1:0] period_ms_i;
  logic               handler_present_i;
  logic [TimeW-1:0]   current_ms_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [PeriodW-1:0] cfg_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [KindW-1:0]   kind_o;
  logic               accepted_o;
  logic [SlotW-1:0]   slot_index_o;
  logic               overran_o;
  logic [TimeW-1:0]   overrun_ms_o;
  logic [TimeW-1:0]   release_ms_o;
  logic               last_item_o;

  int fail_count;
  int pending;

  // Shared between the stimulus and the result sink.
  bit               hold_out;
  int               rush_left;
  int               send_quiet;
  int               sink_quiet;
  int unsigned      lp_cur;
  logic [TimeW-1:0] now_ms;

  timeslice_task_scheduler_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .period_ms_i       (period_ms_i),
    .handler_present_i (handler_present_i),
    .current_ms_i      (current_ms_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .accepted_o        (accepted_o),
    .slot_index_o      (slot_index_o),
    .overran_o         (overran_o),
    .overrun_ms_o      (overrun_ms_o),
    .release_ms_o      (release_ms_o),
    .last_item_o       (last_item_o)
  );

  tss_result_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .func_i            (func_i),
    .period_ms_i       (period_ms_i),
    .handler_present_i (handler_present_i),
    .current_ms_i      (current_ms_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_i            (kind_o),
    .accepted_i        (accepted_o),
    .slot_index_i      (slot_index_o),
    .overran_i         (overran_o),
    .overrun_ms_i      (overrun_ms_o),
    .release_ms_i      (release_ms_o),
    .last_item_i       (last_item_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Gap before each input beat, with stretches of back-to-back beats.
  function automatic int sender_gap();
    if (rush_left > 0) begin
      rush_left--;
      return 0;
    end
    if (send_quiet > 0) begin
      send_quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      send_quiet = $urandom_range(5, 20);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Stall before each result beat, with stretches of no stalling.
  function automatic int sink_stall();
    if (sink_quiet > 0) begin
      sink_quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      sink_quiet = $urandom_range(5, 20);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Offers one input beat and returns once it has been taken.
  task automatic send_beat(
    input logic [FuncW-1:0]   func,
    input logic [PeriodW-1:0] period,
    input logic               handler,
    input logic [TimeW-1:0]   stamp
  );
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    func_i            <= func;
    period_ms_i       <= period;
    handler_present_i <= handler;
    current_ms_i      <= stamp;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // Stops offering beats and waits until every owed result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_loop_period(input logic [PeriodW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    lp_cur = 32'(value);
  endtask

  // One random beat; mostly loop passes that follow the loop period.
  task automatic random_beat(output bit counted);
    int unsigned pick;
    int unsigned k_max;
    int unsigned period;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 55) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: now_ms = now_ms + lp_cur + $urandom_range(0, 4) - 2;
        6, 7:             now_ms = now_ms + $urandom_range(0, 3 * lp_cur);
        8:                now_ms = $urandom();
        default:          now_ms = now_ms + lp_cur;
      endcase
      send_beat(FuncLoop, PeriodW'($urandom()), 1'($urandom()), now_ms);
    end else if (pick < 80) begin
      k_max = 65535 / lp_cur;
      if (k_max > 4) k_max = 4;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: period = lp_cur * $urandom_range(1, k_max);
        6:                period = $urandom_range(0, 65535);
        7:                period = lp_cur * $urandom_range(1, k_max) + $urandom_range(1, 2);
        8:                period = 0;
        default:          period = 65535;
      endcase
      send_beat(FuncRegister, period[PeriodW-1:0], $urandom_range(0, 7) != 0, $urandom());
    end else if (pick < 93) begin
      case ($urandom_range(0, 3))
        0:       now_ms = $urandom();
        1:       now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * lp_cur);
        default: now_ms = now_ms + $urandom_range(0, lp_cur);
      endcase
      send_beat(FuncStart, PeriodW'($urandom()), 1'($urandom()), now_ms);
    end else begin
      counted = 1'b0;
      send_beat(FuncUnused, PeriodW'($urandom()), 1'($urandom()), $urandom());
    end
  endtask

  // Result sink: draws a stall per result beat, or holds off for a long stretch.
  initial begin : result_sink
    bit taken;
    int stall_left;
    out_stall_i = 1'b0;
    stall_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      taken = out_valid_o && !out_stall_i;
      @(negedge clk_i);
      if (hold_out) begin
        hold_out   = 1'b0;
        stall_left = LongHold;
      end else if (taken) begin
        stall_left = sink_stall();
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Ends the run when nothing moves on any channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  // Stimulus.
  initial begin : stimulus
    int  counted;
    bit  took;
    logic [PeriodW-1:0] phase_lp;
    in_valid_i        = 1'b0;
    func_i            = FuncRegister;
    period_ms_i       = '0;
    handler_present_i = 1'b0;
    current_ms_i      = '0;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = '0;
    hold_out          = 1'b0;
    rush_left         = 0;
    send_quiet        = 0;
    sink_quiet        = 0;
    lp_cur            = 32'(LoopPeriodReset);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset loop period of 10 ms.
    send_beat(FuncUnused, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    send_beat(FuncLoop, 16'h0000, 1'b0, 32'd0);
    send_beat(FuncLoop, 16'hFFFF, 1'b1, 32'd21);
    send_beat(FuncLoop, 16'h0000, 1'b0, 32'd31);
    send_beat(FuncRegister, 16'd10, 1'b0, 32'd0);
    send_beat(FuncRegister, 16'd0, 1'b1, 32'hFFFF_FFFF);
    send_beat(FuncRegister, 16'd15, 1'b1, 32'd0);
    send_beat(FuncRegister, 16'd65535, 1'b1, 32'd0);
    send_beat(FuncRegister, 16'd10, 1'b1, 32'd0);
    send_beat(FuncRegister, 16'd20, 1'b1, 32'd0);
    send_beat(FuncRegister, 16'd65530, 1'b1, 32'd0);
    // Millisecond count wrapping past zero between start and loop pass.
    send_beat(FuncStart, 16'h0000, 1'b0, 32'hFFFF_FFFA);
    send_beat(FuncLoop, 16'h0000, 1'b0, 32'd2);
    send_beat(FuncLoop, 16'h0000, 1'b0, 32'd14);
    send_beat(FuncLoop, 16'h0000, 1'b0, 32'd54);
    send_beat(FuncStart, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    send_beat(FuncLoop, 16'h0000, 1'b0, 32'hFFFF_FFFF);
    send_beat(FuncLoop, 16'h0000, 1'b0, 32'h8000_0000);
    send_beat(FuncRegister, 16'd30, 1'b1, 32'hFFFF_FFFF);
    now_ms = 32'h8000_0000;

    // Random phases, each at its own loop period.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       phase_lp = 16'd1;
        1:       phase_lp = 16'd65535;
        2:       phase_lp = PeriodW'($urandom_range(2, 5000));
        default: phase_lp = 16'd7;
      endcase
      drain();
      write_loop_period(phase_lp);
      counted = 0;
      while (counted < PhaseItems) begin
        random_beat(took);
        if (took) counted++;
        // Hold the results back while beats keep coming, so the block backs up.
        if (phase == 0 && took && counted == 30) begin
          hold_out  = 1'b1;
          rush_left = 12;
        end
        if (took && counted == PhaseItems / 2) drain();
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tss_pkg.sv
rtl/tss_ram.sv
rtl/tss_seq.sv
rtl/tss_datapath.sv
rtl/timeslice_task_scheduler_unit.sv
dv/tss_result_checker.sv
dv/tb.sv
